// ===== sv/gpg5x7_pkg.sv =====
// ----------------------------------------------------------------------------
// gpg5x7_pkg
// Font tables, accent codes and lookup helpers for the 5x7 glyph pixel
// generator.
// ----------------------------------------------------------------------------
package gpg5x7_pkg;

  localparam int unsigned CodePointW = 21;
  localparam int unsigned ColW       = 3;
  localparam int unsigned RowW       = 3;
  localparam int unsigned GlyphIdxW  = 7;

  localparam int unsigned GlyphCols  = 5;
  localparam int unsigned GlyphRows  = 7;
  localparam int unsigned FontCount  = 95;

  localparam logic [CodePointW-1:0] FontFirst    = 21'h000020;
  localparam logic [CodePointW-1:0] FontLast     = 21'h00007E;
  localparam logic [CodePointW-1:0] InvExcl      = 21'h0000A1;
  localparam logic [CodePointW-1:0] InvQuest     = 21'h0000BF;
  localparam logic [CodePointW-1:0] LettersFirst = 21'h0000C0;

  localparam logic [7:0] FontFirstChar = 8'h20;
  localparam logic [GlyphIdxW-1:0] QuestIdx = 7'd31;

  typedef logic [7:0] col_byte_t;
  typedef col_byte_t glyph_t [GlyphCols];

  typedef enum logic [2:0] {
    ACC_NONE       = 3'd0,
    ACC_ACUTE      = 3'd1,
    ACC_GRAVE      = 3'd2,
    ACC_CIRCUMFLEX = 3'd3,
    ACC_TILDE      = 3'd4,
    ACC_DIAERESIS  = 3'd5,
    ACC_CEDILLA    = 3'd6
  } accent_e;

  localparam glyph_t InvExclGlyph  = '{8'h00, 8'h00, 8'h79, 8'h00, 8'h00};
  localparam glyph_t InvQuestGlyph = '{8'h04, 8'h48, 8'h48, 8'h28, 8'h10};

  localparam col_byte_t FontRom [FontCount][GlyphCols] = '{
    '{8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h5F,8'h00,8'h00},
    '{8'h00,8'h07,8'h00,8'h07,8'h00}, '{8'h14,8'h7F,8'h14,8'h7F,8'h14},
    '{8'h24,8'h2A,8'h71,8'h2A,8'h12}, '{8'h23,8'h13,8'h08,8'h64,8'h62},
    '{8'h36,8'h49,8'h55,8'h22,8'h50}, '{8'h00,8'h05,8'h03,8'h00,8'h00},
    '{8'h00,8'h1C,8'h22,8'h41,8'h00}, '{8'h00,8'h41,8'h22,8'h1C,8'h00},
    '{8'h08,8'h2A,8'h1C,8'h2A,8'h08}, '{8'h08,8'h08,8'h3E,8'h08,8'h08},
    '{8'h00,8'h00,8'h50,8'h00,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08},
    '{8'h00,8'h00,8'h60,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02},
    '{8'h3E,8'h51,8'h49,8'h45,8'h3E}, '{8'h00,8'h42,8'h7F,8'h40,8'h00},
    '{8'h62,8'h93,8'h91,8'h91,8'h4E}, '{8'h22,8'h81,8'h91,8'h91,8'h7E},
    '{8'h18,8'h28,8'h24,8'h3F,8'h20}, '{8'h7F,8'h89,8'h89,8'h89,8'h06},
    '{8'h7E,8'h89,8'h89,8'h89,8'h76}, '{8'h01,8'h71,8'h09,8'h05,8'h03},
    '{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1E},
    '{8'h00,8'h00,8'h24,8'h00,8'h00}, '{8'h00,8'h50,8'h30,8'h00,8'h00},
    '{8'h00,8'h08,8'h14,8'h22,8'h41}, '{8'h00,8'h14,8'h14,8'h14,8'h14},
    '{8'h41,8'h22,8'h14,8'h08,8'h00}, '{8'h02,8'h01,8'h51,8'h09,8'h06},
    '{8'h3E,8'h41,8'h5D,8'h59,8'h1E}, '{8'h7E,8'h09,8'h09,8'h09,8'h7E},
    '{8'h7F,8'h49,8'h49,8'h49,8'h3E}, '{8'h7E,8'h41,8'h41,8'h41,8'h22},
    '{8'h7F,8'h41,8'h41,8'h41,8'h3E}, '{8'h7F,8'h49,8'h49,8'h49,8'h41},
    '{8'h7F,8'h09,8'h09,8'h09,8'h01}, '{8'h7E,8'h41,8'h41,8'h51,8'h72},
    '{8'h7F,8'h08,8'h08,8'h08,8'h7F}, '{8'h41,8'h41,8'h7F,8'h41,8'h41},
    '{8'h07,8'h04,8'h04,8'h04,8'h7C}, '{8'h7F,8'h08,8'h14,8'h22,8'h41},
    '{8'h7F,8'h40,8'h40,8'h40,8'h40}, '{8'h7F,8'h02,8'h0C,8'h02,8'h7F},
    '{8'h7F,8'h04,8'h08,8'h10,8'h7F}, '{8'h7E,8'h41,8'h41,8'h41,8'h7E},
    '{8'h7F,8'h09,8'h09,8'h09,8'h06}, '{8'h7E,8'h41,8'h51,8'h21,8'h5E},
    '{8'h7F,8'h09,8'h19,8'h29,8'h46}, '{8'h46,8'h49,8'h49,8'h49,8'h31},
    '{8'h01,8'h01,8'h7F,8'h01,8'h01}, '{8'h3F,8'h40,8'h40,8'h40,8'h3F},
    '{8'h1F,8'h20,8'h40,8'h20,8'h1F}, '{8'h7F,8'h20,8'h18,8'h20,8'h7F},
    '{8'h63,8'h14,8'h08,8'h14,8'h63}, '{8'h03,8'h04,8'h78,8'h04,8'h03},
    '{8'h61,8'h51,8'h49,8'h45,8'h43}, '{8'h00,8'h7F,8'h41,8'h41,8'h00},
    '{8'h02,8'h04,8'h08,8'h10,8'h20}, '{8'h00,8'h41,8'h41,8'h7F,8'h00},
    '{8'h04,8'h02,8'h01,8'h02,8'h04}, '{8'h40,8'h40,8'h40,8'h40,8'h40},
    '{8'h00,8'h01,8'h02,8'h04,8'h00}, '{8'h20,8'h54,8'h54,8'h54,8'h78},
    '{8'h7F,8'h48,8'h44,8'h44,8'h38}, '{8'h38,8'h44,8'h44,8'h44,8'h20},
    '{8'h38,8'h44,8'h44,8'h48,8'h7F}, '{8'h38,8'h54,8'h54,8'h54,8'h18},
    '{8'h01,8'h7F,8'h09,8'h09,8'h06}, '{8'h00,8'h38,8'h44,8'h44,8'h38},
    '{8'h7F,8'h08,8'h04,8'h04,8'h38}, '{8'h00,8'h00,8'h4F,8'h00,8'h00},
    '{8'h20,8'h40,8'h40,8'h40,8'h4F}, '{8'h00,8'h7F,8'h10,8'h28,8'h44},
    '{8'h00,8'h41,8'h40,8'h40,8'h40}, '{8'h7C,8'h04,8'h38,8'h04,8'h78},
    '{8'h7C,8'h08,8'h04,8'h04,8'h78}, '{8'h38,8'h44,8'h44,8'h44,8'h38},
    '{8'h7C,8'h14,8'h14,8'h14,8'h08}, '{8'h08,8'h14,8'h14,8'h14,8'h7C},
    '{8'h7C,8'h08,8'h04,8'h04,8'h08}, '{8'h24,8'h4A,8'h4A,8'h4A,8'h12},
    '{8'h04,8'h04,8'h7F,8'h04,8'h04}, '{8'h3C,8'h40,8'h40,8'h40,8'h3C},
    '{8'h1C,8'h20,8'h40,8'h20,8'h1C}, '{8'h3C,8'h40,8'h70,8'h40,8'h3C},
    '{8'h44,8'h28,8'h10,8'h28,8'h44}, '{8'h0C,8'h50,8'h50,8'h50,8'h3C},
    '{8'h44,8'h64,8'h54,8'h4C,8'h44}, '{8'h00,8'h08,8'h14,8'h22,8'h41},
    '{8'h00,8'h00,8'hFF,8'h00,8'h00}, '{8'h41,8'h22,8'h14,8'h08,8'h00},
    '{8'h08,8'h04,8'h08,8'h10,8'h08}
  };

  // Base letter for 0xC0..0xFF; zero means no base letter.
  localparam logic [7:0] LetterBase [64] = '{
    8'h41,8'h41,8'h41,8'h41,8'h41,8'h41,8'h00,8'h43,
    8'h45,8'h45,8'h45,8'h45,8'h49,8'h49,8'h49,8'h49,
    8'h00,8'h4E,8'h4F,8'h4F,8'h4F,8'h4F,8'h4F,8'h00,
    8'h00,8'h55,8'h55,8'h55,8'h55,8'h59,8'h00,8'h00,
    8'h61,8'h61,8'h61,8'h61,8'h61,8'h61,8'h00,8'h63,
    8'h65,8'h65,8'h65,8'h65,8'h69,8'h69,8'h69,8'h69,
    8'h00,8'h6E,8'h6F,8'h6F,8'h6F,8'h6F,8'h6F,8'h00,
    8'h6F,8'h75,8'h75,8'h75,8'h75,8'h79,8'h00,8'h79
  };

  localparam accent_e LetterAccent [64] = '{
    ACC_GRAVE, ACC_ACUTE, ACC_CIRCUMFLEX, ACC_TILDE,
    ACC_DIAERESIS, ACC_NONE, ACC_NONE, ACC_CEDILLA,
    ACC_GRAVE, ACC_ACUTE, ACC_CIRCUMFLEX, ACC_DIAERESIS,
    ACC_GRAVE, ACC_ACUTE, ACC_CIRCUMFLEX, ACC_DIAERESIS,
    ACC_NONE, ACC_TILDE, ACC_GRAVE, ACC_ACUTE,
    ACC_CIRCUMFLEX, ACC_TILDE, ACC_DIAERESIS, ACC_NONE,
    ACC_NONE, ACC_GRAVE, ACC_ACUTE, ACC_CIRCUMFLEX,
    ACC_DIAERESIS, ACC_ACUTE, ACC_NONE, ACC_NONE,
    ACC_GRAVE, ACC_ACUTE, ACC_CIRCUMFLEX, ACC_TILDE,
    ACC_DIAERESIS, ACC_NONE, ACC_NONE, ACC_CEDILLA,
    ACC_GRAVE, ACC_ACUTE, ACC_CIRCUMFLEX, ACC_DIAERESIS,
    ACC_GRAVE, ACC_ACUTE, ACC_CIRCUMFLEX, ACC_DIAERESIS,
    ACC_NONE, ACC_TILDE, ACC_GRAVE, ACC_ACUTE,
    ACC_CIRCUMFLEX, ACC_TILDE, ACC_DIAERESIS, ACC_NONE,
    ACC_NONE, ACC_GRAVE, ACC_ACUTE, ACC_CIRCUMFLEX,
    ACC_DIAERESIS, ACC_ACUTE, ACC_NONE, ACC_DIAERESIS
  };

  function automatic logic accent_bit(accent_e acc, logic [ColW-1:0] col,
                                      logic [RowW-1:0] row);
    logic res;
    res = 1'b0;
    case (acc)
      ACC_ACUTE:      res = (col == 3'd2 && row == 3'd0) ||
                            (col == 3'd3 && row == 3'd1);
      ACC_GRAVE:      res = (col == 3'd2 && row == 3'd0) ||
                            (col == 3'd1 && row == 3'd1);
      ACC_CIRCUMFLEX: res = (row == 3'd0 && (col == 3'd1 || col == 3'd3)) ||
                            (col == 3'd2 && row == 3'd1);
      ACC_TILDE:      res = row == 3'd0 && col >= 3'd1 && col <= 3'd3;
      ACC_DIAERESIS:  res = row == 3'd0 && (col == 3'd1 || col == 3'd3);
      ACC_CEDILLA:    res = row == 3'd6 && col <= 3'd1;
      default:        res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

// ===== sv/glyph_pixel_generator_5x7_top.sv =====
// ----------------------------------------------------------------------------
// glyph_pixel_generator_5x7_top
// Returns one pixel of a 5x7 glyph for a code point, a column and a row.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle while the input is ready and
// delivers its pixel from a registered output; the lookup in the font table
// and the accent overlay are done in the accepting cycle and the result is
// written into a two-entry output buffer. The input stays ready while that
// buffer holds fewer than two results, so a result may wait on the output
// while the next beat is taken, and a stalled output stops the input only
// once two results are waiting. The block holds no other state.
module glyph_pixel_generator_5x7_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [gpg5x7_pkg::CodePointW-1:0]  code_point_i,
  input  logic [gpg5x7_pkg::ColW-1:0]        column_i,
  input  logic [gpg5x7_pkg::RowW-1:0]        row_index_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               pixel_on_o
);

  logic                               in_font;
  logic                               is_letter;
  logic                               pos_ok;
  logic [gpg5x7_pkg::ColW-1:0]        col_sel;
  logic [5:0]                         letter_k;
  logic [7:0]                         base_char;
  logic [gpg5x7_pkg::GlyphIdxW-1:0]   base_off;
  logic [gpg5x7_pkg::GlyphIdxW-1:0]   glyph_idx;
  gpg5x7_pkg::col_byte_t              font_byte;
  gpg5x7_pkg::col_byte_t              excl_byte;
  gpg5x7_pkg::col_byte_t              quest_byte;
  logic                               pix;

  logic [1:0] cnt_q, cnt_d;
  logic       slot0_q, slot0_d;
  logic       slot1_q, slot1_d;
  logic       push;
  logic       pop;

  always_comb begin
    pos_ok    = (column_i < 3'(gpg5x7_pkg::GlyphCols)) &&
                (row_index_i < 3'(gpg5x7_pkg::GlyphRows));
    col_sel   = (column_i < 3'(gpg5x7_pkg::GlyphCols)) ? column_i : '0;
    in_font   = (code_point_i >= gpg5x7_pkg::FontFirst) &&
                (code_point_i <= gpg5x7_pkg::FontLast);
    letter_k  = code_point_i[5:0];
    base_char = gpg5x7_pkg::LetterBase[letter_k];
    is_letter = (code_point_i[20:6] == gpg5x7_pkg::LettersFirst[20:6]) &&
                (base_char != 8'h00);
    base_off  = base_char[6:0] - gpg5x7_pkg::FontFirstChar[6:0];
    if (in_font) begin
      glyph_idx = code_point_i[6:0] - gpg5x7_pkg::FontFirstChar[6:0];
    end else if (is_letter) begin
      glyph_idx = base_off;
    end else begin
      glyph_idx = gpg5x7_pkg::QuestIdx;
    end
    font_byte  = gpg5x7_pkg::FontRom[glyph_idx][col_sel];
    excl_byte  = gpg5x7_pkg::InvExclGlyph[col_sel];
    quest_byte = gpg5x7_pkg::InvQuestGlyph[col_sel];

    if (!pos_ok) begin
      pix = 1'b0;
    end else if (in_font) begin
      pix = font_byte[row_index_i];
    end else if (code_point_i == gpg5x7_pkg::InvExcl) begin
      pix = excl_byte[row_index_i];
    end else if (code_point_i == gpg5x7_pkg::InvQuest) begin
      pix = quest_byte[row_index_i];
    end else if (is_letter) begin
      pix = font_byte[row_index_i] |
            gpg5x7_pkg::accent_bit(gpg5x7_pkg::LetterAccent[letter_k],
                                   column_i, row_index_i);
    end else begin
      pix = font_byte[row_index_i];
    end
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign pixel_on_o  = slot0_q;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    case (cnt_q)
      2'd0: begin
        if (push) begin
          slot0_d = pix;
          cnt_d   = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          slot0_d = pix;
        end else if (push) begin
          slot1_d = pix;
          cnt_d   = 2'd2;
        end else if (pop) begin
          cnt_d = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          slot0_d = slot1_q;
          cnt_d   = 2'd1;
        end
      end
      default: begin
        cnt_d = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  // An accepted beat into an empty buffer shows up on the output next cycle.
  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && cnt_q == 2'd0) |=> out_valid_o)
    else $error("accepted beat did not reach the output");

  // A position outside the glyph cell always gives a dark pixel.
  a_blank_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && cnt_q == 2'd0 && (column_i >= 3'd5 || row_index_i == 3'd7))
      |=> !pixel_on_o)
    else $error("pixel lit outside the glyph cell");

  // A full buffer stays full while the output is stalled.
  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !out_ready_i) |=> (cnt_q == 2'd2))
    else $error("buffer lost a result while stalled");

endmodule
